>>> design/rod_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rod_pkg
// Types and constants shared by the RGB565 ordered dither pipeline.
// ----------------------------------------------------------------------------
package rod_pkg;

  // Port payloads
  typedef struct packed {
    logic [15:0] pixel_in;
    logic [2:0]  col_phase;
    logic [2:0]  row_phase;
  } rod_in_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        is_black;
  } rod_out_t;

  // Stage 1: channels widened to 8 bits
  typedef struct packed {
    logic       vld;
    logic [7:0] red;
    logic [7:0] grn;
    logic [7:0] blu;
    logic [2:0] col;
    logic [2:0] row;
  } rod_s1_t;

  // Stage 3: tone classified, offset above the black point
  typedef struct packed {
    logic       vld;
    logic       dark;
    logic       light;
    logic [7:0] ofs;
    logic [2:0] col;
    logic [2:0] row;
  } rod_s3_t;

  // Channel widening x*255/31 and x*255/63 as reciprocal multiplies
  localparam logic [31:0] EXP5_MUL   = 32'd2156535;  // 255 * ceil(2^18 / 31)
  localparam int          EXP5_SHIFT = 18;
  localparam logic [31:0] EXP6_MUL   = 32'd4244475;  // 255 * ceil(2^20 / 63)
  localparam int          EXP6_SHIFT = 20;

  // Luma weights
  localparam logic [7:0] W_RED = 8'd54;
  localparam logic [7:0] W_GRN = 8'd183;
  localparam logic [7:0] W_BLU = 8'd19;

  // Spread / 5 as (s * 205) >> 10, exact for 8-bit s
  localparam logic [7:0] DIV5_MUL   = 8'd205;
  localparam int         DIV5_SHIFT = 10;

  localparam logic signed [8:0] TONE_LO   = 9'sd72;
  localparam logic signed [8:0] TONE_HI   = 9'sd246;
  localparam logic [7:0]        BLACK_OFS = 8'd72;

  // Level = (ofs*64 + 87) / 174 as (n * ceil(2^21 / 174)) >> 21
  localparam logic [13:0] LVL_BIAS  = 14'd87;
  localparam logic [13:0] LVL_MUL   = 14'd12053;
  localparam int          LVL_SHIFT = 21;

  localparam logic [15:0] PIX_BLACK = 16'h0000;
  localparam logic [15:0] PIX_WHITE = 16'hFFFF;

  // 8x8 Bayer thresholds, indexed by {row, col}
  localparam logic [5:0] BAYER [0:63] = '{
    6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
    6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
    6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
    6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
    6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
    6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
    6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
    6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
  };

endpackage
`default_nettype wire

>>> design/rod_expand.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rod_expand
// Stage 1: split the RGB565 beat and widen each channel to 8 bits.
// ----------------------------------------------------------------------------
module rod_expand (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_vld,
  input  rod_pkg::rod_in_t in_data,
  output rod_pkg::rod_s1_t s1
);
  import rod_pkg::*;

  logic        vld_r;
  logic [7:0]  red_r, grn_r, blu_r, red_nxt, grn_nxt, blu_nxt;
  logic [2:0]  col_r, row_r;
  logic [31:0] red_p, grn_p, blu_p;

  always_comb begin
    red_p   = {27'd0, in_data.pixel_in[15:11]} * EXP5_MUL;
    grn_p   = {26'd0, in_data.pixel_in[10:5]} * EXP6_MUL;
    blu_p   = {27'd0, in_data.pixel_in[4:0]} * EXP5_MUL;
    red_nxt = red_p[EXP5_SHIFT +: 8];
    grn_nxt = grn_p[EXP6_SHIFT +: 8];
    blu_nxt = blu_p[EXP5_SHIFT +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    red_r <= red_nxt;
    grn_r <= grn_nxt;
    blu_r <= blu_nxt;
    col_r <= in_data.col_phase;
    row_r <= in_data.row_phase;
  end

  assign s1 = '{vld: vld_r, red: red_r, grn: grn_r, blu: blu_r, col: col_r, row: row_r};

endmodule
`default_nettype wire

>>> design/rod_tone.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rod_tone
// Stages 2 and 3: weighted luma and channel spread, then tone and its class.
// ----------------------------------------------------------------------------
module rod_tone (
  input  wire              clk,
  input  wire              rst_n,
  input  rod_pkg::rod_s1_t s1,
  output rod_pkg::rod_s3_t s3
);
  import rod_pkg::*;

  // Stage 2
  logic        s2_vld_r;
  logic [7:0]  luma_r, spread_r, luma_nxt, spread_nxt;
  logic [2:0]  s2_col_r, s2_row_r;
  logic [15:0] luma_sum;
  logic [7:0]  hi, lo;

  always_comb begin
    luma_sum = ({8'd0, s1.red} * {8'd0, W_RED}) + ({8'd0, s1.grn} * {8'd0, W_GRN})
             + ({8'd0, s1.blu} * {8'd0, W_BLU});
    luma_nxt = luma_sum[15:8];
    hi = (s1.red > s1.grn) ? s1.red : s1.grn;
    lo = (s1.red < s1.grn) ? s1.red : s1.grn;
    if (s1.blu > hi) begin
      hi = s1.blu;
    end
    if (s1.blu < lo) begin
      lo = s1.blu;
    end
    spread_nxt = hi - lo;
  end

  // Stage 3
  logic              s3_vld_r;
  logic              dark_r, light_r, dark_nxt, light_nxt;
  logic [7:0]        ofs_r, ofs_nxt;
  logic [2:0]        s3_col_r, s3_row_r;
  logic [15:0]       q_p;
  logic signed [8:0] tone;

  always_comb begin
    q_p       = {8'd0, spread_r} * {8'd0, DIV5_MUL};
    tone      = $signed({1'b0, luma_r}) - $signed({3'b000, q_p[DIV5_SHIFT +: 6]});
    dark_nxt  = (tone <= TONE_LO);
    light_nxt = (tone >= TONE_HI);
    ofs_nxt   = tone[7:0] - BLACK_OFS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1.vld;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    luma_r   <= luma_nxt;
    spread_r <= spread_nxt;
    s2_col_r <= s1.col;
    s2_row_r <= s1.row;
    dark_r   <= dark_nxt;
    light_r  <= light_nxt;
    ofs_r    <= ofs_nxt;
    s3_col_r <= s2_col_r;
    s3_row_r <= s2_row_r;
  end

  assign s3 = '{vld: s3_vld_r, dark: dark_r, light: light_r, ofs: ofs_r,
                col: s3_col_r, row: s3_row_r};

endmodule
`default_nettype wire

>>> design/rod_thresh.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rod_thresh
// Stages 4 and 5: dither level and Bayer threshold, then the black/white pick.
// ----------------------------------------------------------------------------
module rod_thresh (
  input  wire               clk,
  input  wire               rst_n,
  input  rod_pkg::rod_s3_t  s3,
  output logic              out_vld,
  output rod_pkg::rod_out_t out_data
);
  import rod_pkg::*;

  // Stage 4
  logic        s4_vld_r;
  logic        dark_r, light_r;
  logic [6:0]  level_r, level_nxt;
  logic [5:0]  thr_r, thr_nxt;
  logic [13:0] num;
  logic [27:0] lvl_p;

  always_comb begin
    num       = {s3.ofs, 6'd0} + LVL_BIAS;
    lvl_p     = {14'd0, num} * {14'd0, LVL_MUL};
    level_nxt = lvl_p[LVL_SHIFT +: 7];
    thr_nxt   = BAYER[{s3.row, s3.col}];
  end

  // Stage 5
  logic     out_vld_r;
  logic     black_r, black_nxt;

  always_comb begin
    black_nxt = dark_r || (!light_r && ({1'b0, thr_r} >= level_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s4_vld_r  <= s3.vld;
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dark_r  <= s3.dark;
    light_r <= s3.light;
    level_r <= level_nxt;
    thr_r   <= thr_nxt;
    black_r <= black_nxt;
  end

  assign out_vld            = out_vld_r;
  assign out_data.is_black  = black_r;
  assign out_data.pixel_out = black_r ? PIX_BLACK : PIX_WHITE;

endmodule
`default_nettype wire

>>> design/rgb565_ordered_dither_bw_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb565_ordered_dither_bw_top
// One-bit ordered dither of an RGB565 pixel stream with an 8x8 Bayer matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Drive start high with in_data (pixel, column and row phase) to send a
//   beat; it is taken at any edge where start is high and busy is low.
//   busy is high only while rst_n is asserted, so one pixel can enter on
//   every clock.
//   Each result appears on out_data for a single cycle with out_valid high:
//   pixel_out is 0x0000 or 0xFFFF and is_black marks the black case.
//   Each accepted beat passes through the five-stage pipeline (widen,
//   luma/spread, tone, level/threshold, pick) to the result; throughput is
//   one pixel per cycle.
//   The receiver has no back-pressure: results must be taken as they come.
//   Reset clears all stage valid bits, so beats in flight are dropped.
//   The pixel source walks the frame and supplies the phases itself.
// ----------------------------------------------------------------------------
module rgb565_ordered_dither_bw_top (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  rod_pkg::rod_in_t  in_data,
  output logic              out_valid,
  output rod_pkg::rod_out_t out_data
);
  import rod_pkg::*;

  rod_s1_t s1;
  rod_s3_t s3;
  logic    accept;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  rod_expand u_expand (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_data (in_data),
    .s1      (s1)
  );

  rod_tone u_tone (
    .clk   (clk),
    .rst_n (rst_n),
    .s1    (s1),
    .s3    (s3)
  );

  rod_thresh u_thresh (
    .clk      (clk),
    .rst_n    (rst_n),
    .s3       (s3),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

  // Every result beat traces back to an earlier accepted beat
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("result beat without matching input beat");

  // Every accepted beat yields a result
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("accepted beat produced no result");

  // Output pixel agrees with the black flag
  a_pixel_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pixel_out == (out_data.is_black ? PIX_BLACK : PIX_WHITE)))
    else $error("pixel_out disagrees with is_black");

  // Full white input always comes out white
  a_white_in: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.pixel_in == 16'hFFFF)) |-> ##5 (out_valid && !out_data.is_black))
    else $error("white pixel dithered to black");

endmodule
`default_nettype wire

>>> tb/sv/rgb565_ordered_dither_bw_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb565_ordered_dither_bw_top_tb
// Self-checking bench for the RGB565 to black/white ordered dither. A queue
// of pixel beats (directed corners, then random colours, near-grey tones and
// raster phase walks) feeds a driver with random idle bursts. Every accepted
// beat is predicted here and checked in order against the result strobe.
// ----------------------------------------------------------------------------
module rgb565_ordered_dither_bw_top_tb;

  import rod_pkg::rod_in_t;
  import rod_pkg::rod_out_t;

  localparam int TONE_BLACK  = 72;
  localparam int TONE_WHITE  = 246;
  localparam int RANDOM_BEATS = 1800;
  localparam int TAIL_BEATS  = 200;   // last beats go in back to back
  localparam int MAX_REPORTS = 10;

  localparam logic [15:0] RGB_BLACK = 16'h0000;
  localparam logic [15:0] RGB_WHITE = 16'hFFFF;

  // 8x8 Bayer thresholds, [row][col]
  localparam int THRESH [0:7][0:7] = '{
    '{ 0, 48, 12, 60,  3, 51, 15, 63},
    '{32, 16, 44, 28, 35, 19, 47, 31},
    '{ 8, 56,  4, 52, 11, 59,  7, 55},
    '{40, 24, 36, 20, 43, 27, 39, 23},
    '{ 2, 50, 14, 62,  1, 49, 13, 61},
    '{34, 18, 46, 30, 33, 17, 45, 29},
    '{10, 58,  6, 54,  9, 57,  5, 53},
    '{42, 26, 38, 22, 41, 25, 37, 21}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  rod_in_t  in_data = '0;
  logic     out_valid;
  rod_out_t out_data;

  rod_in_t  pending_pixels [$];
  rod_out_t expected_pixels [$];
  int       idle_left = 0;
  int       mismatches = 0;

  rgb565_ordered_dither_bw_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic rod_out_t dither_pixel(rod_in_t beat);
    int red, grn, blu, hi, lo, luma, tone, level;
    logic dark;
    rod_out_t res;
    red = int'(beat.pixel_in[15:11]) * 255 / 31;
    grn = int'(beat.pixel_in[10:5]) * 255 / 63;
    blu = int'(beat.pixel_in[4:0]) * 255 / 31;
    hi = (red > grn) ? red : grn;
    lo = (red < grn) ? red : grn;
    if (blu > hi) hi = blu;
    if (blu < lo) lo = blu;
    luma = (red * 54 + grn * 183 + blu * 19) / 256;
    // may go negative for dark saturated colours, which lands below black
    tone = luma - (hi - lo) / 5;
    if (tone <= TONE_BLACK) begin
      dark = 1'b1;
    end else if (tone >= TONE_WHITE) begin
      dark = 1'b0;
    end else begin
      level = ((tone - TONE_BLACK) * 64 + (TONE_WHITE - TONE_BLACK) / 2)
              / (TONE_WHITE - TONE_BLACK);
      dark = THRESH[beat.row_phase][beat.col_phase] >= level;
    end
    res.pixel_out = dark ? RGB_BLACK : RGB_WHITE;
    res.is_black  = dark;
    return res;
  endfunction

  task automatic queue_pixel(input logic [15:0] px, input int col, input int row);
    rod_in_t beat;
    beat.pixel_in  = px;
    beat.col_phase = col[2:0];
    beat.row_phase = row[2:0];
    pending_pixels.push_back(beat);
  endtask

  // Driver: hold a beat until taken, otherwise idle or advance
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_pixels.push_back(dither_pixel(in_data));
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left = idle_left - 1;
          start <= 1'b0;
        end else if (pending_pixels.size() > TAIL_BEATS && $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(0, 16);
          start <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          in_data <= pending_pixels.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction
  always @(posedge clk) begin : monitor
    rod_out_t want;
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected beat: pixel_out=%h is_black=%b",
                   out_data.pixel_out, out_data.is_black);
        mismatches = mismatches + 1;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.pixel_out !== want.pixel_out || out_data.is_black !== want.is_black) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: pixel_out exp %h got %h, is_black exp %b got %b",
                     want.pixel_out, out_data.pixel_out, want.is_black, out_data.is_black);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  initial begin : stimulus
    int g6, r5, b5, col, row;
    // corners, pure primaries, both phase extremes
    queue_pixel(16'h0000, 0, 0);
    queue_pixel(16'hFFFF, 7, 7);
    queue_pixel(16'hFFFF, 0, 0);
    queue_pixel(16'h0000, 7, 7);
    queue_pixel(16'hF800, 3, 5);
    queue_pixel(16'h07E0, 5, 3);
    queue_pixel(16'h001F, 1, 6);
    queue_pixel(16'hFFE0, 2, 4);
    queue_pixel(16'h07FF, 6, 1);
    queue_pixel(16'hF81F, 4, 2);
    // dark saturated blue (tone below zero), then dark saturated red
    queue_pixel(16'h0010, 0, 0);
    queue_pixel(16'h8000, 7, 0);
    // grey right on the black point, then just above
    queue_pixel(16'h4A49, 0, 0);
    queue_pixel(16'h4A69, 0, 0);
    queue_pixel(16'h4A69, 3, 1);
    // grey right on the white point, then just below
    queue_pixel(16'hF7BE, 7, 7);
    queue_pixel(16'hF79E, 7, 3);
    queue_pixel(16'hF79E, 0, 0);
    // mid grey over a spread of thresholds
    queue_pixel(16'h8410, 0, 0);
    queue_pixel(16'h8410, 3, 0);
    queue_pixel(16'h8410, 4, 4);
    queue_pixel(16'h8410, 7, 1);
    queue_pixel(16'h8410, 1, 6);
    queue_pixel(16'hAAAA, 5, 2);
    queue_pixel(16'h5555, 2, 5);

    col = 0;
    row = 0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      case ($urandom_range(0, 2))
        0: queue_pixel(16'($urandom), $urandom_range(0, 7), $urandom_range(0, 7));
        1: begin
          // near-grey so that most tones fall between the two points
          g6 = $urandom_range(0, 63);
          r5 = (g6 >> 1) + $urandom_range(0, 2) - 1;
          b5 = (g6 >> 1) + $urandom_range(0, 2) - 1;
          if (r5 < 0) r5 = 0;
          if (r5 > 31) r5 = 31;
          if (b5 < 0) b5 = 0;
          if (b5 > 31) b5 = 31;
          queue_pixel({r5[4:0], g6[5:0], b5[4:0]}, $urandom_range(0, 7),
                      $urandom_range(0, 7));
        end
        default: begin
          // raster walk over the phases with a random colour
          queue_pixel(16'($urandom), col, row);
          col = (col + 1) % 8;
          if (col == 0) row = (row + 1) % 8;
        end
      endcase
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pixels.size() != 0 || start) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("rgb565_ordered_dither_bw_top_tb: clean");
    end else begin
      $display("rgb565_ordered_dither_bw_top_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("rgb565_ordered_dither_bw_top_tb: errors");
    $finish;
  end

endmodule
